[rtl/core/vfc_pkg.sv]
// Shared types, codes and constants for the voxel face cull quad emitter.
package vfc_pkg;

  // Material codes
  localparam logic [1:0] MAT_AIR   = 2'd0;
  localparam logic [1:0] MAT_GRASS = 2'd1;

  // Face order: left, right, bottom, top, back, front
  localparam int unsigned NUM_FACES = 6;
  localparam logic [2:0] FACE_LEFT   = 3'd0;
  localparam logic [2:0] FACE_RIGHT  = 3'd1;
  localparam logic [2:0] FACE_BOTTOM = 3'd2;
  localparam logic [2:0] FACE_TOP    = 3'd3;
  localparam logic [2:0] FACE_BACK   = 3'd4;
  localparam logic [2:0] FACE_FRONT  = 3'd5;

  localparam logic [1:0] AXIS_Y = 2'd1;

  // Texture layers
  localparam int unsigned LAYER_W = 10;
  localparam logic [LAYER_W-1:0] LAYER_GRASS_TOP  = 10'd0;
  localparam logic [LAYER_W-1:0] LAYER_GRASS_SIDE = 10'd1;
  localparam logic [LAYER_W-1:0] LAYER_DIRT       = 10'd2;

  localparam int unsigned COORD_W  = 10;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned VOXEL_W  = 30;
  localparam int unsigned POS_W    = 30;
  localparam int unsigned ATTR_W   = 13;

  // One input word, last field in the lowest bits
  typedef struct packed {
    logic [NUM_FACES-1:0][1:0] nb_type;   // [0] left ... [5] ahead
    logic [1:0]                voxel_type;
    logic [3:0]                pos_z;
    logic [7:0]                pos_y;
    logic [3:0]                pos_x;
  } voxel_t;

  // Voxel being drained and the faces still to emit
  typedef struct packed {
    voxel_t                 voxel;
    logic [NUM_FACES-1:0]   mask;
  } face_job_t;

  typedef struct packed {
    logic              last_face;
    logic [ATTR_W-1:0] attribute_word;
    logic [POS_W-1:0]  position_word;
  } quad_t;

endpackage

[rtl/core/voxel_face_cull_quad_emit_core.sv]
// Top level of the voxel face cull quad emitter.
// Takes one voxel word (position, material, six neighbour materials) and emits
// one quad word per air neighbour of a non-air voxel, in the order left, right,
// bottom, top, back, front; tlast marks the voxel's final quad. Air voxels and
// fully enclosed voxels produce no output. A voxel with exposed faces holds
// the input register until its last quad leaves, as the single output register
// takes one quad per cycle unless m_tready stalls it; voxels with zero or one
// exposed face stream at one per cycle unless stalled. Each quad goes from
// input to output register; s_tready depends combinationally on m_tready.
module voxel_face_cull_quad_emit_core
  import vfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // pos_x[3:0], pos_y[11:4], pos_z[15:12], voxel_type[17:16], left_type[19:18],
  // right_type[21:20], below_type[23:22], above_type[25:24],
  // behind_type[27:26], ahead_type[29:28], zero pad[31:30]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // position_word[29:0], attribute_word[42:30], zero pad[47:43]
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast   // last_face
);

  face_job_t job;
  quad_t     quad;
  logic      load;

  vfc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .load     (load),
    .job      (job)
  );

  vfc_quad_build u_build (
    .job  (job),
    .quad (quad)
  );

  vfc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .pend     (job.mask != '0),
    .quad     (quad),
    .load     (load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/core/vfc_in_stage.sv]
// Input register: holds one voxel and the mask of exposed faces left to emit.
module vfc_in_stage
  import vfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,
  input  logic                 load,     // output register takes a quad this cycle
  output face_job_t            job
);

  voxel_t               voxel;
  voxel_t               voxel_in;
  logic [NUM_FACES-1:0] mask;
  logic [NUM_FACES-1:0] mask_in;
  logic [NUM_FACES-1:0] rest;
  logic                 pend;
  logic                 take;

  assign voxel_in = voxel_t'(s_tdata[VOXEL_W-1:0]);

  // exposed faces of the incoming voxel; air voxels expose nothing
  always_comb begin
    for (int i = 0; i < NUM_FACES; i++) begin
      mask_in[i] = (voxel_in.voxel_type != MAT_AIR) && (voxel_in.nb_type[i] == MAT_AIR);
    end
  end

  // drop the lowest face once it moves to the output
  assign pend     = (mask != '0);
  assign take     = pend && load;
  assign rest     = mask & (mask - NUM_FACES'(1));
  assign s_tready = !pend || (take && (rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (s_tvalid && s_tready) begin
      mask <= mask_in;
    end else if (take) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      voxel <= voxel_in;
    end
  end

  assign job.voxel = voxel;
  assign job.mask  = mask;

endmodule

[rtl/core/vfc_quad_build.sv]
// Picks the lowest pending face and packs its quad.
module vfc_quad_build
  import vfc_pkg::*;
(
  input  face_job_t job,
  output quad_t     quad
);

  logic [2:0]         face;
  logic [1:0]         axis;
  logic               offset;
  logic               grass;
  logic [LAYER_W-1:0] layer;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [COORD_W-1:0] qz;
  logic [NUM_FACES-1:0] rest;

  // lowest set bit wins
  always_comb begin
    face = FACE_LEFT;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (job.mask[i]) begin
        face = 3'(i);
      end
    end
  end

  assign axis   = face[2:1];
  assign offset = face[0];
  assign grass  = (job.voxel.voxel_type == MAT_GRASS);

  // offset faces sit one unit along their axis
  assign qx = COORD_W'(job.voxel.pos_x) + COORD_W'(face == FACE_RIGHT);
  assign qy = COORD_W'(job.voxel.pos_y) + COORD_W'(face == FACE_TOP);
  assign qz = COORD_W'(job.voxel.pos_z) + COORD_W'(face == FACE_FRONT);

  // grass: grass-top layer on top, dirt on bottom, grass-side on sides; else dirt
  always_comb begin
    layer = LAYER_DIRT;
    if (grass) begin
      if (axis == AXIS_Y) begin
        layer = offset ? LAYER_GRASS_TOP : LAYER_DIRT;
      end else begin
        layer = LAYER_GRASS_SIDE;
      end
    end
  end

  assign rest = job.mask & (job.mask - NUM_FACES'(1));

  assign quad.position_word  = {qz, qy, qx};
  assign quad.attribute_word = {axis, ~offset, layer};
  assign quad.last_face      = (rest == '0);

endmodule

[rtl/core/vfc_out_stage.sv]
// Output register for one quad word.
module vfc_out_stage
  import vfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pend,
  input  quad_t            quad,
  output logic             load,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  quad_t q;

  assign load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= quad;
    end
  end

  assign m_tdata = {(OUT_W - POS_W - ATTR_W)'(0), q.attribute_word, q.position_word};
  assign m_tlast = q.last_face;

endmodule

[rtl/core/vfc_checker.sv]
// Port-level checks for the quad emitter, bound to the top level.
module vfc_checker
  import vfc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // normal index is one of the six faces
  a_normal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[42:40] != 3'd6) && (m_tdata[42:40] != 3'd7))
    else $error("bad normal index");

  // layer is 0..2 and pad bits are zero
  a_layer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:32] == 8'd0) && (m_tdata[31:30] != 2'd3)
                 && (m_tdata[47:43] == 5'd0))
    else $error("bad layer or pad");

  // an air voxel leaves nothing pending
  a_air: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[17:16] == 2'd0) |=> s_tready)
    else $error("air voxel blocked input");

endmodule

bind voxel_face_cull_quad_emit_core vfc_checker u_vfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
